// ===== src/ebgt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebgt_pkg
// Shared types and constants of the encoder and button gesture tracker.
// ----------------------------------------------------------------------------
package ebgt_pkg;

  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned TimeWidth    = 32;
  localparam int unsigned PosWidth     = 32;
  localparam int unsigned DeltaWidth   = 8;

  localparam logic [CfgDataWidth-1:0] DebounceMsRst  = 16'd50;
  localparam logic [CfgDataWidth-1:0] LongPressMsRst = 16'd500;

  localparam logic signed [DeltaWidth-1:0] DeltaMax = 8'sd127;
  localparam logic signed [DeltaWidth-1:0] DeltaMin = -8'sd128;

  typedef enum logic [0:0] {
    CFG_DEBOUNCE_MS   = 1'b0,
    CFG_LONG_PRESS_MS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [TimeWidth-1:0]       now_ms;
    logic signed [PosWidth-1:0] encoder_position;
    logic                       button_pressed;
    logic                       take_delta;
    logic                       take_short;
    logic                       take_long;
  } sample_t;

  typedef struct packed {
    logic signed [DeltaWidth-1:0] rotation_delta;
    logic                         short_press;
    logic                         long_press;
    logic                         button_held;
  } result_t;

endpackage

// ===== src/ebgt_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebgt_core
// Gesture state and single-pass update: rotation sum, debounce, long press.
// ----------------------------------------------------------------------------
module ebgt_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                step_i,
  input  wire ebgt_pkg::sample_t                   sample_i,
  input  wire logic [ebgt_pkg::CfgDataWidth-1:0]   debounce_ms_i,
  input  wire logic [ebgt_pkg::CfgDataWidth-1:0]   hold_limit_i,
  output ebgt_pkg::result_t                        result_o
);

  localparam int unsigned TW = ebgt_pkg::TimeWidth;
  localparam int unsigned PW = ebgt_pkg::PosWidth;
  localparam int unsigned DW = ebgt_pkg::DeltaWidth;
  localparam int unsigned PadW = TW - ebgt_pkg::CfgDataWidth;

  logic [PW-1:0]        last_pos_q,   last_pos_d;
  logic signed [DW-1:0] pend_q,       pend_d;
  logic                 short_q,      short_d;
  logic                 long_q,       long_d;
  logic                 down_q,       down_d;
  logic                 fired_q,      fired_d;
  logic [TW-1:0]        start_q,      start_d;
  logic [TW-1:0]        last_edge_q,  last_edge_d;

  always_comb begin
    logic [PW:0]          diff;
    logic signed [DW-1:0] step_delta;
    logic [DW:0]          sum;
    logic signed [DW-1:0] pend_n;
    logic                 edge_ok;
    logic                 short_n;
    logic                 long_n;
    logic                 down_n;
    logic                 fired_n;
    logic [TW-1:0]        start_n;
    logic [TW-1:0]        last_edge_n;
    logic [TW-1:0]        since_edge;
    logic [TW-1:0]        held_for;

    // clamp the exact position change
    diff = {sample_i.encoder_position[PW-1], sample_i.encoder_position}
         - {last_pos_q[PW-1], last_pos_q};
    if (!diff[PW] && (|diff[PW-1:DW-1])) begin
      step_delta = ebgt_pkg::DeltaMax;
    end else if (diff[PW] && !(&diff[PW-1:DW-1])) begin
      step_delta = ebgt_pkg::DeltaMin;
    end else begin
      step_delta = diff[DW-1:0];
    end

    // saturating pending sum
    sum = {pend_q[DW-1], pend_q} + {step_delta[DW-1], step_delta};
    if (sum[DW] != sum[DW-1]) begin
      pend_n = sum[DW] ? ebgt_pkg::DeltaMin : ebgt_pkg::DeltaMax;
    end else begin
      pend_n = sum[DW-1:0];
    end

    // debounced edges
    since_edge  = sample_i.now_ms - last_edge_q;
    edge_ok     = (sample_i.button_pressed != down_q)
                && (since_edge > {{PadW{1'b0}}, debounce_ms_i});
    short_n     = short_q;
    long_n      = long_q;
    down_n      = down_q;
    fired_n     = fired_q;
    start_n     = start_q;
    last_edge_n = last_edge_q;
    if (edge_ok) begin
      last_edge_n = sample_i.now_ms;
      fired_n     = 1'b0;
      down_n      = sample_i.button_pressed;
      if (sample_i.button_pressed) begin
        start_n = sample_i.now_ms;
      end else if (!fired_q) begin
        short_n = 1'b1;
      end
    end

    // long press while held
    held_for = sample_i.now_ms - start_n;
    if (down_n && !fired_n && (held_for >= {{PadW{1'b0}}, hold_limit_i})) begin
      long_n  = 1'b1;
      fired_n = 1'b1;
    end

    result_o.rotation_delta = pend_n;
    result_o.short_press    = short_n;
    result_o.long_press     = long_n;
    result_o.button_held    = down_n;

    last_pos_d  = sample_i.encoder_position;
    pend_d      = sample_i.take_delta ? '0 : pend_n;
    short_d     = sample_i.take_short ? 1'b0 : short_n;
    long_d      = sample_i.take_long ? 1'b0 : long_n;
    down_d      = down_n;
    fired_d     = fired_n;
    start_d     = start_n;
    last_edge_d = last_edge_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q  <= '0;
      pend_q      <= '0;
      short_q     <= 1'b0;
      long_q      <= 1'b0;
      down_q      <= 1'b0;
      fired_q     <= 1'b0;
      start_q     <= '0;
      last_edge_q <= '0;
    end else if (step_i) begin
      last_pos_q  <= last_pos_d;
      pend_q      <= pend_d;
      short_q     <= short_d;
      long_q      <= long_d;
      down_q      <= down_d;
      fired_q     <= fired_d;
      start_q     <= start_d;
      last_edge_q <= last_edge_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/encoder_button_gesture_tracker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted sample beat passes the sample register, then the result register.
// Throughput: one sample per cycle while the receiver takes results; the
// single-pass gesture update in ebgt_core sets the pace, one state update per sample.
// Reset: pipeline empty, gesture state cleared, debounce time 50 ms,
// long-press hold time 500 ms.
// ----------------------------------------------------------------------------
// encoder_button_gesture_tracker_top
// Sample register, gesture update and result register with valid/ready.
// ----------------------------------------------------------------------------
module encoder_button_gesture_tracker_top (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic [0:0]                              cfg_idx_i,
  input  wire logic [ebgt_pkg::CfgDataWidth-1:0]       cfg_data_i,
  input  wire logic                                    in_valid_i,
  output logic                                         in_ready_o,
  input  wire logic [ebgt_pkg::TimeWidth-1:0]          now_ms_i,
  input  wire logic signed [ebgt_pkg::PosWidth-1:0]    encoder_position_i,
  input  wire logic                                    button_pressed_i,
  input  wire logic                                    take_delta_i,
  input  wire logic                                    take_short_i,
  input  wire logic                                    take_long_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output logic signed [ebgt_pkg::DeltaWidth-1:0]       rotation_delta_o,
  output logic                                         short_press_o,
  output logic                                         long_press_o,
  output logic                                         button_held_o
);

  logic [ebgt_pkg::CfgDataWidth-1:0] debounce_q;
  logic [ebgt_pkg::CfgDataWidth-1:0] long_press_q;

  logic              in_vld_q;
  ebgt_pkg::sample_t sample_q;
  logic              out_vld_q;
  ebgt_pkg::result_t result_q;
  ebgt_pkg::result_t result_d;
  logic              advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= ebgt_pkg::DebounceMsRst;
      long_press_q <= ebgt_pkg::LongPressMsRst;
    end else if (cfg_we_i) begin
      unique case (ebgt_pkg::cfg_reg_e'(cfg_idx_i))
        ebgt_pkg::CFG_DEBOUNCE_MS:   debounce_q   <= cfg_data_i;
        ebgt_pkg::CFG_LONG_PRESS_MS: long_press_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // hold payload registers until the next beat
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q.now_ms           <= now_ms_i;
      sample_q.encoder_position <= encoder_position_i;
      sample_q.button_pressed   <= button_pressed_i;
      sample_q.take_delta       <= take_delta_i;
      sample_q.take_short       <= take_short_i;
      sample_q.take_long        <= take_long_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  ebgt_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .sample_i        (sample_q),
    .debounce_ms_i   (debounce_q),
    .hold_limit_i    (long_press_q),
    .result_o        (result_d)
  );

  assign out_valid_o      = out_vld_q;
  assign rotation_delta_o = result_q.rotation_delta;
  assign short_press_o    = result_q.short_press;
  assign long_press_o     = result_q.long_press;
  assign button_held_o    = result_q.button_held;

endmodule
`default_nettype wire

// ===== dv/tb_encoder_button_gesture_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_button_gesture_tracker_top
// Self-checking bench for the encoder and button gesture tracker. A queued
// driver offers sample beats in random bursts and a monitor predicts every
// result from its own copy of the gesture state, then compares each result
// beat field by field. Timing registers are reprogrammed between phases,
// extremes included, and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_encoder_button_gesture_tracker_top;
  import ebgt_pkg::*;

  localparam int unsigned CycleLimit     = 300000;
  localparam int unsigned LongHoldAfter  = 400;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned DrainCycles    = 10;
  localparam int unsigned PhaseItems     = 162;
  localparam int unsigned NumPhases      = 7;

  logic                         clk_i              = 1'b0;
  logic                         rst_ni             = 1'b0;
  logic                         cfg_we_i           = 1'b0;
  logic [0:0]                   cfg_idx_i          = CFG_DEBOUNCE_MS;
  logic [CfgDataWidth-1:0]      cfg_data_i         = '0;
  logic                         in_valid_i         = 1'b0;
  logic                         in_ready_o;
  logic [TimeWidth-1:0]         now_ms_i           = '0;
  logic signed [PosWidth-1:0]   encoder_position_i = '0;
  logic                         button_pressed_i   = 1'b0;
  logic                         take_delta_i       = 1'b0;
  logic                         take_short_i       = 1'b0;
  logic                         take_long_i        = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i        = 1'b0;
  logic signed [DeltaWidth-1:0] rotation_delta_o;
  logic                         short_press_o;
  logic                         long_press_o;
  logic                         button_held_o;

  encoder_button_gesture_tracker_top dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .now_ms_i,
    .encoder_position_i,
    .button_pressed_i,
    .take_delta_i,
    .take_short_i,
    .take_long_i,
    .out_valid_o,
    .out_ready_i,
    .rotation_delta_o,
    .short_press_o,
    .long_press_o,
    .button_held_o
  );

  always #5 clk_i = ~clk_i;

  // Gesture state mirror
  logic [CfgDataWidth-1:0]      debounce_cfg  = DebounceMsRst;
  logic [CfgDataWidth-1:0]      long_cfg      = LongPressMsRst;
  logic [PosWidth-1:0]          prev_position = '0;
  logic signed [DeltaWidth-1:0] delta_acc     = '0;
  logic                         short_pending = 1'b0;
  logic                         long_pending  = 1'b0;
  logic                         btn_down      = 1'b0;
  logic                         long_done     = 1'b0;
  logic [TimeWidth-1:0]         press_t0      = '0;
  logic [TimeWidth-1:0]         edge_t        = '0;

  sample_t     pending_samples_q[$];
  result_t     expected_results_q[$];
  sample_t     next_sample;
  result_t     oldest_result;
  int unsigned samples_queued   = 0;
  int unsigned samples_accepted = 0;
  int unsigned results_checked  = 0;
  int unsigned shorts_predicted = 0;
  int unsigned longs_predicted  = 0;
  int unsigned mismatches       = 0;
  int unsigned cycle_count      = 0;

  int unsigned burst_left = 1;
  int unsigned send_gap   = 0;
  int unsigned rx_cycle   = 0;
  int unsigned rx_beats   = 0;
  int unsigned hold_left  = 0;
  logic        long_hold_done = 1'b0;

  logic [TimeWidth-1:0] gen_time  = '0;
  logic [PosWidth-1:0]  gen_pos   = '0;
  logic                 gen_level = 1'b0;

  int unsigned debounce_list[NumPhases] = '{0, 65535, 20, 1000, 65535, 5, 50};
  int unsigned long_list[NumPhases]     = '{1, 65535, 100, 65535, 1, 30, 500};

  function automatic logic signed [DeltaWidth-1:0] clamp_delta(logic signed [32:0] v);
    if (v > DeltaMax) return DeltaMax;
    if (v < DeltaMin) return DeltaMin;
    return v[DeltaWidth-1:0];
  endfunction

  function automatic result_t predict_gesture(sample_t smp);
    logic signed [32:0] pos_step;
    logic signed [32:0] acc_sum;
    logic [31:0]        since_edge;
    logic [31:0]        held_for;
    result_t            res;
    pos_step = $signed({smp.encoder_position[31], smp.encoder_position})
             - $signed({prev_position[31], prev_position});
    prev_position = smp.encoder_position;
    acc_sum = $signed({{25{delta_acc[7]}}, delta_acc}) + clamp_delta(pos_step);
    delta_acc = clamp_delta(acc_sum);

    since_edge = smp.now_ms - edge_t;
    if (smp.button_pressed != btn_down && since_edge > 32'(debounce_cfg)) begin
      edge_t = smp.now_ms;
      if (smp.button_pressed) begin
        btn_down  = 1'b1;
        press_t0  = smp.now_ms;
        long_done = 1'b0;
      end else begin
        if (!long_done) begin
          short_pending = 1'b1;
          shorts_predicted++;
        end
        btn_down  = 1'b0;
        long_done = 1'b0;
      end
    end

    held_for = smp.now_ms - press_t0;
    if (btn_down && !long_done && held_for >= 32'(long_cfg)) begin
      long_pending = 1'b1;
      long_done    = 1'b1;
      longs_predicted++;
    end

    res.rotation_delta = delta_acc;
    res.short_press    = short_pending;
    res.long_press     = long_pending;
    res.button_held    = btn_down;

    if (smp.take_delta) delta_acc = '0;
    if (smp.take_short) short_pending = 1'b0;
    if (smp.take_long) long_pending = 1'b0;
    return res;
  endfunction

  task automatic check_field(string fname, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Sender: bursts of beats with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_samples_q.size() > 0) begin
        next_sample = pending_samples_q.pop_front();
        now_ms_i           <= next_sample.now_ms;
        encoder_position_i <= next_sample.encoder_position;
        button_pressed_i   <= next_sample.button_pressed;
        take_delta_i       <= next_sample.take_delta;
        take_short_i       <= next_sample.take_short;
        take_long_i        <= next_sample.take_long;
        in_valid_i         <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          send_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: own stall pattern plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rx_cycle++;
      if (out_valid_o && out_ready_i) rx_beats++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!long_hold_done && rx_beats >= LongHoldAfter) begin
        long_hold_done = 1'b1;
        hold_left      = LongHoldCycles;
        out_ready_i <= 1'b0;
      end else begin
        case ((rx_cycle / 97) % 4)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= (rx_cycle % 3 == 0);
        endcase
      end
    end
  end

  // Monitor: predict on sample beats, compare on result beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results_q.push_back(predict_gesture({now_ms_i, encoder_position_i,
          button_pressed_i, take_delta_i, take_short_i, take_long_i}));
        samples_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got delta %0d",
                   $time, rotation_delta_o);
          mismatches++;
        end else begin
          oldest_result = expected_results_q.pop_front();
          check_field("rotation_delta", $signed(oldest_result.rotation_delta),
                      $signed(rotation_delta_o));
          check_field("short_press", oldest_result.short_press, short_press_o);
          check_field("long_press", oldest_result.long_press, long_press_o);
          check_field("button_held", oldest_result.button_held, button_held_o);
          results_checked++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic queue_sample(logic [31:0] t, logic [31:0] pos, logic btn,
                              logic td, logic ts, logic tl);
    pending_samples_q.push_back({t, pos, btn, td, ts, tl});
    samples_queued++;
  endtask

  task automatic wait_idle();
    while (samples_accepted != samples_queued || expected_results_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic set_timing(logic [15:0] db, logic [15:0] lp);
    wait_idle();
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_DEBOUNCE_MS;
    cfg_data_i <= db;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_LONG_PRESS_MS;
    cfg_data_i <= lp;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    debounce_cfg = db;
    long_cfg     = lp;
  endtask

  task automatic queue_random_samples(int unsigned count);
    logic [31:0] step;
    logic        lvl;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: step = $urandom_range(0, 3);
        3, 4:    step = 32'(debounce_cfg) + $urandom_range(0, 2) - 1;
        5, 6:    step = $urandom_range(0, debounce_cfg + 4);
        7:       step = 32'(long_cfg) - $urandom_range(0, 2);
        8:       step = $urandom();
        default: step = -32'($urandom_range(1, 100));
      endcase
      gen_time = gen_time + step;

      pick = $urandom_range(0, 19);
      if (pick == 0) gen_pos = $urandom();
      else if (pick == 1) gen_pos = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      else if (pick < 5) gen_pos = gen_pos + 32'($urandom_range(0, 600)) - 32'd300;
      else gen_pos = gen_pos + 32'($urandom_range(0, 10)) - 32'd5;

      // hold the level mostly, toggle it sometimes, bounce it briefly now and then
      pick = $urandom_range(0, 99);
      if (pick < 20) gen_level = ~gen_level;
      lvl = (pick >= 20 && pick < 28) ? ~gen_level : gen_level;

      queue_sample(gen_time, gen_pos, lvl, $urandom_range(0, 3) == 0,
                   $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edges at or before the debounce time after reset, then a clamped jump
    queue_sample(32'd10, 32'd0, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_sample(32'd50, 32'd0, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_sample(32'd51, 32'd1000, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_sample(32'd551, -32'sd1000, 1'b1, 1'b1, 1'b0, 1'b0);
    queue_sample(32'd600, -32'sd1000, 1'b0, 1'b0, 1'b0, 1'b1);
    queue_sample(32'd700, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_sample(32'd720, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_sample(32'd800, 32'h8000_0000, 1'b0, 1'b1, 1'b1, 1'b0);
    queue_sample(32'd801, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0);
    // hold across the timestamp wrap, then let time run backwards
    queue_sample(32'hFFFF_FFF0, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_sample(32'h0000_0010, 32'd0, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_sample(32'h0000_01F0, 32'd0, 1'b1, 1'b1, 1'b1, 1'b1);
    queue_sample(32'h0000_0300, 32'd5, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_sample(32'h0000_0200, 32'd5, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_sample(32'h0000_0100, 32'd5, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_sample(32'h0000_0100, 32'd5, 1'b0, 1'b1, 1'b1, 1'b1);

    // zero debounce and zero long-press time
    set_timing(16'd0, 16'd0);
    queue_sample(32'h0000_0100, 32'd5, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_sample(32'h0000_0101, 32'd6, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_sample(32'h0000_0102, 32'd6, 1'b0, 1'b0, 1'b0, 1'b1);
    queue_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
    queue_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0);
    gen_time = 32'hFFFF_FFFF;
    gen_pos  = 32'hFFFF_FFFF;

    for (int p = 0; p < NumPhases; p++) begin
      set_timing(debounce_list[p][15:0], long_list[p][15:0]);
      queue_random_samples(PhaseItems);
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    $display("%0d sample beats checked over %0d timing settings", results_checked,
             NumPhases + 2);
    $display("%0d short presses and %0d long presses predicted", shorts_predicted,
             longs_predicted);
    if (mismatches == 0 && expected_results_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
